### rtl/dutc_pkg.sv
// ============================================================================
// dutc_pkg - shared types and constants for the DOS/UTC timestamp converter
// Request and response types, stage control, the reciprocal constants for
// the divisions by constants and the March-based month start table.
// ============================================================================
`default_nettype none

package dutc_pkg;

    // Register stages between the request and the response port.
    localparam int STAGES = 6;

    localparam int TIME_W = 33;
    localparam int DOS_W  = 32;
    localparam int DAY_W  = 17;   // day counts up to 2^33 / 86400
    localparam int SOD_W  = 17;   // second of day, also 31:63:62 out of range

    localparam logic [TIME_W-1:0] SECS_PER_DAY = TIME_W'(86400);

    // Day 0 of both directions is 1968-03-01, the start of a leap cycle.
    // Days from there to 1970-01-01.
    localparam logic [DAY_W-1:0] EPOCH_TO_MAR1968 = DAY_W'(671);
    // Days since 1970-01-01 of 2100-03-01, where the leap cycle breaks.
    localparam logic [DAY_W-1:0] MAR2100_DAY = DAY_W'(47541);
    // Year index (years after 1968) of 2100, counted from March.
    localparam logic [7:0] YEAR_IDX_2100 = 8'd132;
    // Year index of 1980 and of 2107, the DOS year window.
    localparam logic [8:0] DOS_YEAR_FIRST = 9'd12;
    localparam logic [8:0] DOS_YEAR_LAST  = 9'd139;

    localparam logic [10:0] DAYS_PER_YEAR  = 11'd365;
    localparam logic [16:0] DAYS_PER_CYCLE = 17'd1461;

    // floor(x / 675) = (x * RECIP_675) >> 36 for x < 2^26
    localparam logic [26:0] RECIP_675  = 27'd101806633;
    // floor(x / 15) = (x * RECIP_15) >> 19 for x < 2^15
    localparam logic [15:0] RECIP_15   = 16'd34953;
    // floor(x / 1461) = (x * RECIP_1461) >> 31 for x < 2^17
    localparam logic [20:0] RECIP_1461 = 21'd1469873;

    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] time_value;
    } req_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_out;
        logic              range_error;
    } rsp_t;

    // Per-stage load strobes handed from the control to the datapaths.
    typedef struct packed {
        logic [STAGES-1:0] load;
    } stage_ctl_t;

    // Day of year (from March 1st) on which March-based month mp starts.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        unique case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/dutc_dos2utc.sv
// ============================================================================
// dutc_dos2utc - DOS date/time word to UTC seconds
// Unpacks and normalises the fields, counts days, scales to seconds and
// delays the result to the common pipeline depth.
// ============================================================================
`default_nettype none

module dutc_dos2utc
    import dutc_pkg::*;
(
    input  wire logic              clk,
    input  wire stage_ctl_t        ctl,
    input  wire logic [DOS_W-1:0]  word,
    output logic      [TIME_W-1:0] time_out
);

    logic [3:0]       mfield;
    logic [3:0]       mon;
    logic [3:0]       mp;
    logic [7:0]       yy;
    logic [DAY_W-1:0] days_next;
    logic [SOD_W-1:0] sod_next;

    logic [DAY_W-1:0]  days1_reg;
    logic [SOD_W-1:0]  sod1_reg;
    logic              zero1_reg;
    logic [TIME_W-1:0] prod2_reg;
    logic [SOD_W-1:0]  sod2_reg;
    logic              zero2_reg;
    logic [TIME_W-1:0] tot3_reg;
    logic [TIME_W-1:0] tot4_reg;
    logic [TIME_W-1:0] tot5_reg;
    logic [TIME_W-1:0] tot6_reg;
    logic [TIME_W-1:0] tot3_next;

    // Normalise month 0 into December before and months past 12 into the
    // year after; January and February count with the previous March year.
    always_comb
    begin
        mfield = word[24:21];
        yy     = 8'(word[31:25]) + 8'(DOS_YEAR_FIRST);
        mon    = mfield;
        if (mfield == 4'd0)
        begin
            mon = 4'd12;
            yy  = yy - 8'd1;
        end
        else if (mfield >= 4'd13)
        begin
            mon = mfield - 4'd12;
            yy  = yy + 8'd1;
        end
        if (mon <= 4'd2)
        begin
            yy = yy - 8'd1;
            mp = mon + 4'd9;
        end
        else
        begin
            mp = mon - 4'd3;
        end
    end

    assign days_next = DAY_W'(yy) * DAY_W'(365) + DAY_W'(yy[7:2])
                     + DAY_W'(month_start(mp)) + DAY_W'(word[20:16])
                     - EPOCH_TO_MAR1968 - DAY_W'(1)
                     - DAY_W'(yy >= YEAR_IDX_2100);

    assign sod_next = SOD_W'(word[15:11]) * SOD_W'(3600)
                    + SOD_W'(word[10:5]) * SOD_W'(60)
                    + SOD_W'({word[4:0], 1'b0});

    assign tot3_next = zero2_reg ? '0 : prod2_reg + TIME_W'(sod2_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            days1_reg <= days_next;
            sod1_reg  <= sod_next;
            zero1_reg <= (word == '0);
        end
        if (ctl.load[1])
        begin
            prod2_reg <= TIME_W'(days1_reg) * SECS_PER_DAY;
            sod2_reg  <= sod1_reg;
            zero2_reg <= zero1_reg;
        end
        if (ctl.load[2])
        begin
            tot3_reg <= tot3_next;
        end
        if (ctl.load[3])
        begin
            tot4_reg <= tot3_reg;
        end
        if (ctl.load[4])
        begin
            tot5_reg <= tot4_reg;
        end
        if (ctl.load[5])
        begin
            tot6_reg <= tot5_reg;
        end
    end

    assign time_out = tot6_reg;

endmodule

`default_nettype wire

### rtl/dutc_utc2dos.sv
// ============================================================================
// dutc_utc2dos - UTC seconds to DOS date/time word
// Splits seconds into days and time of day by reciprocal multiplication,
// walks leap cycles, years and months, then range checks and packs.
// ============================================================================
`default_nettype none

module dutc_utc2dos
    import dutc_pkg::*;
(
    input  wire logic              clk,
    input  wire stage_ctl_t        ctl,
    input  wire logic [TIME_W-1:0] secs,
    output logic      [DOS_W-1:0]  word,
    output logic                   range_error
);

    // Stage 1: scaled reciprocal of the day count
    logic [52:0]       p1_reg;
    logic [TIME_W-1:0] t1_reg;
    logic              zero1_reg;

    // Stage 2: day count and second of day
    logic [DAY_W-1:0]  days2;
    logic [TIME_W-1:0] rem_full;
    logic [SOD_W-1:0]  rem2_reg;
    logic [DAY_W-1:0]  dj2_reg;
    logic              zero2_reg;

    // Stage 3: minutes of day, scaled leap cycle count
    logic [29:0]       mprod;
    logic [10:0]       mins3_reg;
    logic [37:0]       cm3_reg;
    logic [SOD_W-1:0]  rem3_reg;
    logic [DAY_W-1:0]  dj3_reg;
    logic              zero3_reg;

    // Stage 4: cycle, day in cycle, hour, second
    logic [6:0]        cyc4;
    logic [DAY_W-1:0]  r_full;
    logic [SOD_W-1:0]  sec_full;
    logic [23:0]       hprod;
    logic [10:0]       r4_reg;
    logic [6:0]        cyc4_reg;
    logic [5:0]        sec4_reg;
    logic [4:0]        hour4_reg;
    logic [10:0]       mins4_reg;
    logic              zero4_reg;

    // Stage 5: year in cycle, day of year, minute
    logic [1:0]        yoc;
    logic [10:0]       doy_full;
    logic [10:0]       min_full;
    logic [1:0]        yoc5_reg;
    logic [8:0]        doy5_reg;
    logic [6:0]        cyc5_reg;
    logic [5:0]        sec5_reg;
    logic [5:0]        min5_reg;
    logic [4:0]        hour5_reg;
    logic              zero5_reg;

    // Stage 6: month, day, year check and pack
    logic [3:0]        mp;
    logic [3:0]        mon;
    logic [8:0]        mday_full;
    logic [8:0]        yo;
    logic [8:0]        yfield;
    logic              in_window;
    logic [DOS_W-1:0]  word6_reg;
    logic              err6_reg;

    assign days2    = p1_reg[52:36];
    assign rem_full = t1_reg - TIME_W'(days2) * SECS_PER_DAY;

    assign mprod = 30'(rem2_reg[16:2]) * 30'(RECIP_15);

    assign cyc4     = cm3_reg[37:31];
    assign r_full   = dj3_reg - DAY_W'(cyc4) * DAYS_PER_CYCLE;
    assign sec_full = rem3_reg - SOD_W'(mins3_reg) * SOD_W'(60);
    assign hprod    = 24'(mins3_reg[10:2]) * 24'(RECIP_15);

    assign yoc = 2'(r4_reg >= DAYS_PER_YEAR)
               + 2'(r4_reg >= 11'(2 * 365))
               + 2'(r4_reg >= 11'(3 * 365));
    assign doy_full = r4_reg - 11'(yoc) * DAYS_PER_YEAR;
    assign min_full = mins4_reg - 11'(hour4_reg) * 11'd60;

    // Count the month starts already passed.
    always_comb
    begin
        mp = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy5_reg >= month_start(4'(i)))
            begin
                mp = mp + 4'd1;
            end
        end
    end

    assign mon       = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    assign mday_full = doy5_reg - month_start(mp) + 9'd1;
    assign yo        = 9'({cyc5_reg, 2'b00}) + 9'(yoc5_reg) + 9'(mp >= 4'd10);
    assign in_window = (yo >= DOS_YEAR_FIRST) && (yo <= DOS_YEAR_LAST);
    assign yfield    = yo - DOS_YEAR_FIRST;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            p1_reg    <= 53'(secs[32:7]) * 53'(RECIP_675);
            t1_reg    <= secs;
            zero1_reg <= (secs == '0);
        end
        if (ctl.load[1])
        begin
            rem2_reg  <= rem_full[SOD_W-1:0];
            // skip the missing leap day of 2100 to keep four-year cycles
            dj2_reg   <= days2 + EPOCH_TO_MAR1968 + DAY_W'(days2 >= MAR2100_DAY);
            zero2_reg <= zero1_reg;
        end
        if (ctl.load[2])
        begin
            mins3_reg <= mprod[29:19];
            cm3_reg   <= 38'(dj2_reg) * 38'(RECIP_1461);
            rem3_reg  <= rem2_reg;
            dj3_reg   <= dj2_reg;
            zero3_reg <= zero2_reg;
        end
        if (ctl.load[3])
        begin
            r4_reg    <= r_full[10:0];
            cyc4_reg  <= cyc4;
            sec4_reg  <= sec_full[5:0];
            hour4_reg <= hprod[23:19];
            mins4_reg <= mins3_reg;
            zero4_reg <= zero3_reg;
        end
        if (ctl.load[4])
        begin
            yoc5_reg  <= yoc;
            doy5_reg  <= doy_full[8:0];
            cyc5_reg  <= cyc4_reg;
            sec5_reg  <= sec4_reg;
            min5_reg  <= min_full[5:0];
            hour5_reg <= hour4_reg;
            zero5_reg <= zero4_reg;
        end
        if (ctl.load[5])
        begin
            if (in_window && !zero5_reg)
            begin
                word6_reg <= {yfield[6:0], mon, mday_full[4:0], hour5_reg,
                              min5_reg, sec5_reg[5:1]};
            end
            else
            begin
                word6_reg <= '0;
            end
            err6_reg <= !in_window && !zero5_reg;
        end
    end

    assign word        = word6_reg;
    assign range_error = err6_reg;

endmodule

`default_nettype wire

### rtl/dos_unix_timestamp_converter.sv
// ============================================================================
// dos_unix_timestamp_converter - DOS date/time word <-> UTC seconds
// Six-stage pipeline converting one timestamp per request in either
// direction, with an elastic valid/stall handshake on both ports.
// ============================================================================
//
//   Port   | Handshake            | Payload
//   -------+----------------------+-------------------------------------
//   req    | req_valid/req_stall  | func, time_value (DOS word or UTC s)
//   rsp    | rsp_valid/rsp_stall  | time_out, range_error
//
// A request is taken every cycle while req_stall is low; its response is
// valid once it has passed all stages and leaves when rsp_stall is low.
// Both directions run side by side through the same six register stages,
// each stage at most one multiplier deep; func picks the result at the end.
// Reset clears the stage valid bits only; the datapath needs no flush.
// A stall on rsp holds the last stage; earlier stages keep filling any
// empty slots, so req_stall rises only when every stage holds a request.
// ============================================================================
`default_nettype none

module dos_unix_timestamp_converter
    import dutc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] func_reg;
    logic [STAGES:0]   room;
    stage_ctl_t        ctl;

    logic [TIME_W-1:0] dos_secs;
    logic [DOS_W-1:0]  utc_word;
    logic              utc_err;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb
    begin
        room[STAGES] = !rsp_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            room[k] = !valid_reg[k] || room[k+1];
        end
        ctl.load = room[STAGES-1:0];
    end

    // Advance valid bits along with the data; a bubble clears the stage.
    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (!ctl.load[k])
            begin
                valid_next[k] = valid_reg[k];
            end
            else if (k == 0)
            begin
                valid_next[k] = req_valid;
            end
            else
            begin
                valid_next[k] = valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Carry the direction of each request alongside it.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (ctl.load[k])
            begin
                func_reg[k] <= (k == 0) ? req.func : func_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    dutc_dos2utc u_dos2utc
    (
        .clk      (clk),
        .ctl      (ctl),
        .word     (req.time_value[DOS_W-1:0]),
        .time_out (dos_secs)
    );

    dutc_utc2dos u_utc2dos
    (
        .clk         (clk),
        .ctl         (ctl),
        .secs        (req.time_value),
        .word        (utc_word),
        .range_error (utc_err)
    );

    assign req_stall = !room[0];
    assign rsp_valid = valid_reg[STAGES-1];

    // Select the finished result by direction; both sides are registered.
    always_comb
    begin
        if (func_reg[STAGES-1])
        begin
            rsp.time_out    = TIME_W'(utc_word);
            rsp.range_error = utc_err;
        end
        else
        begin
            rsp.time_out    = dos_secs;
            rsp.range_error = 1'b0;
        end
    end

endmodule

`default_nettype wire
